[src/stereo_delay_line_mix_assert.svh]
// Assertion macros used by the back part of the delay line mixer RTL.
`ifndef STEREO_DELAY_LINE_MIX_ASSERT_SVH
`define STEREO_DELAY_LINE_MIX_ASSERT_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define SDLM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever ante holds at a clock edge, cons must hold at the next edge.
`define SDLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sdlm_pkg.sv]
// Shared types and constants of the stereo delay line mixer.
package sdlm_pkg;

    localparam int DEPTH       = 262144;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int SAMPLE_W    = 24;
    localparam int GAIN_W      = 16;
    localparam int DELAY_W     = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;
    localparam int PHASE_W     = 13;
    localparam int WETK_W      = GAIN_W + PHASE_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // 0.2 in Q0.15, rounded.
    localparam logic [PHASE_W-1:0] PHASE_Q15 = 13'd6554;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN     = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_left;
        logic [SAMPLE_W-1:0] sample_right;
        logic [ADDR_W-1:0]   wr_addr;
        logic [ADDR_W-1:0]   rd_addr;
        logic                hist_valid;
        logic [GAIN_W-1:0]   dry_gain;
        logic [WETK_W-1:0]   wet_k;
    } t_entry;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM
    } t_back_state;

endpackage

[src/sdlm_queue.sv]
// Two-entry queue between the front and back parts of the mixer.
module sdlm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sdlm_pkg::t_entry  i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output sdlm_pkg::t_entry  o_entry
);

    sdlm_pkg::t_entry                r_slot [sdlm_pkg::QUEUE_DEPTH];
    logic [sdlm_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [sdlm_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [sdlm_pkg::QCNT_W-1:0]     r_count;

    assign o_full  = (r_count == sdlm_pkg::QCNT_W'(sdlm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/sdlm_front.sv]
// Front part: configuration registers, write position and read address setup.
module sdlm_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sdlm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sdlm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_s_valid,
    output logic                              o_s_ready,
    input  logic [sdlm_pkg::SAMPLE_W-1:0]     i_s_left,
    input  logic [sdlm_pkg::SAMPLE_W-1:0]     i_s_right,
    output logic                              o_push,
    output sdlm_pkg::t_entry                  o_entry,
    input  logic                              i_full
);

    localparam logic [sdlm_pkg::ADDR_W-1:0] LAST_ADDR =
        sdlm_pkg::ADDR_W'(sdlm_pkg::DEPTH - 1);

    logic [sdlm_pkg::DELAY_W-1:0] r_delay;
    logic [sdlm_pkg::GAIN_W-1:0]  r_dry;
    logic [sdlm_pkg::GAIN_W-1:0]  r_wet;
    logic [sdlm_pkg::ADDR_W-1:0]  r_wr_pos;
    logic [sdlm_pkg::ADDR_W-1:0]  r_fill;
    logic [sdlm_pkg::ADDR_W-1:0]  n_wr_pos;
    logic [sdlm_pkg::ADDR_W-1:0]  n_fill;
    logic [sdlm_pkg::DELAY_W-1:0] delay_eff;
    logic [sdlm_pkg::ADDR_W-1:0]  delay_addr;

    assign o_s_ready = !i_full;
    assign o_push    = i_s_valid && !i_full;

    // Clamp the delay to 1..DEPTH-1.
    always_comb begin
        if (r_delay == '0) begin
            delay_eff = sdlm_pkg::DELAY_W'(1);
        end else if ({1'b0, r_delay} > (sdlm_pkg::DELAY_W + 1)'(sdlm_pkg::DEPTH - 1)) begin
            delay_eff = sdlm_pkg::DELAY_W'(sdlm_pkg::DEPTH - 1);
        end else begin
            delay_eff = r_delay;
        end
        delay_addr = sdlm_pkg::ADDR_W'(delay_eff);
    end

    // The fill count tells whether the read entry has been written since reset;
    // an entry never written reads as zero.
    always_comb begin
        o_entry.sample_left  = i_s_left;
        o_entry.sample_right = i_s_right;
        o_entry.wr_addr      = r_wr_pos;
        o_entry.rd_addr      = r_wr_pos - delay_addr;
        o_entry.hist_valid   = (delay_addr <= r_fill);
        o_entry.dry_gain     = r_dry;
        o_entry.wet_k        = sdlm_pkg::WETK_W'(r_wet) *
                               sdlm_pkg::WETK_W'(sdlm_pkg::PHASE_Q15);
        n_wr_pos             = r_wr_pos + 1'b1;
        n_fill               = (r_fill == LAST_ADDR) ? r_fill : r_fill + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= sdlm_pkg::DELAY_W'(1);
            r_dry    <= sdlm_pkg::GAIN_W'(32768);
            r_wet    <= '0;
            r_wr_pos <= LAST_ADDR;
            r_fill   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sdlm_pkg::CFG_DELAY_FRAMES: r_delay <= i_cfg_data[sdlm_pkg::DELAY_W-1:0];
                    sdlm_pkg::CFG_DRY_GAIN:     r_dry   <= i_cfg_data[sdlm_pkg::GAIN_W-1:0];
                    sdlm_pkg::CFG_WET_GAIN:     r_wet   <= i_cfg_data[sdlm_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (o_push) begin
                r_wr_pos <= n_wr_pos;
                r_fill   <= n_fill;
            end
        end
    end

endmodule

[src/sdlm_back.sv]
// Back part: history memories, gain multiplies, rounding and saturation.
`include "stereo_delay_line_mix_assert.svh"

module sdlm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  sdlm_pkg::t_entry              i_q_entry,
    output logic                          o_pop,
    output logic                          o_m_valid,
    input  logic                          i_m_ready,
    output logic [sdlm_pkg::SAMPLE_W-1:0] o_m_left,
    output logic [sdlm_pkg::SAMPLE_W-1:0] o_m_right
);

    localparam int PD_W    = sdlm_pkg::GAIN_W + 1 + sdlm_pkg::SAMPLE_W;
    localparam int PW_W    = sdlm_pkg::WETK_W + 1 + sdlm_pkg::SAMPLE_W;
    localparam int ACC_W   = PD_W + 15 + 2;
    localparam int Q_W     = ACC_W - 30;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** 29);
    localparam logic signed [Q_W-1:0]   SAT_HI = Q_W'(2 ** (sdlm_pkg::SAMPLE_W - 1) - 1);
    localparam logic signed [Q_W-1:0]   SAT_LO = -SAT_HI - Q_W'(1);

    logic [sdlm_pkg::SAMPLE_W-1:0] r_hist_l [sdlm_pkg::DEPTH];
    logic [sdlm_pkg::SAMPLE_W-1:0] r_hist_r [sdlm_pkg::DEPTH];

    sdlm_pkg::t_back_state         r_state;
    sdlm_pkg::t_back_state         n_state;
    sdlm_pkg::t_entry              r_cur;
    logic [sdlm_pkg::SAMPLE_W-1:0] r_rd_l;
    logic [sdlm_pkg::SAMPLE_W-1:0] r_rd_r;
    logic signed [PD_W-1:0]        r_pd_l;
    logic signed [PD_W-1:0]        r_pd_r;
    logic signed [PW_W-1:0]        r_pw_l;
    logic signed [PW_W-1:0]        r_pw_r;
    logic                          r_out_valid;
    logic [sdlm_pkg::SAMPLE_W-1:0] r_out_l;
    logic [sdlm_pkg::SAMPLE_W-1:0] r_out_r;
    logic                          load_out;
    logic signed [sdlm_pkg::SAMPLE_W-1:0] delayed_l;
    logic signed [sdlm_pkg::SAMPLE_W-1:0] delayed_r;

    // Sum of the two products, round half up at bit 30, saturate to the sample range.
    function automatic logic [sdlm_pkg::SAMPLE_W-1:0] mix_sat(
        input logic signed [PD_W-1:0] pd,
        input logic signed [PW_W-1:0] pw
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [Q_W-1:0]   q;
        acc = (ACC_W'(pd) <<< 15) + ACC_W'(pw) + ROUND_BIAS;
        q   = $signed(acc[ACC_W-1:30]);
        if (q > SAT_HI) begin
            mix_sat = sdlm_pkg::SAMPLE_W'(SAT_HI);
        end else if (q < SAT_LO) begin
            mix_sat = sdlm_pkg::SAMPLE_W'(SAT_LO);
        end else begin
            mix_sat = q[sdlm_pkg::SAMPLE_W-1:0];
        end
    endfunction

    assign o_m_valid = r_out_valid;
    assign o_m_left  = r_out_l;
    assign o_m_right = r_out_r;
    assign delayed_l = r_cur.hist_valid ? $signed(r_rd_l) : '0;
    assign delayed_r = r_cur.hist_valid ? $signed(r_rd_r) : '0;

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            sdlm_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = sdlm_pkg::BK_MUL;
                end
            end
            sdlm_pkg::BK_MUL: begin
                n_state = sdlm_pkg::BK_SUM;
            end
            sdlm_pkg::BK_SUM: begin
                if (!r_out_valid || i_m_ready) begin
                    load_out = 1'b1;
                    n_state  = sdlm_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = sdlm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdlm_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The read address always trails the write address, so the two never collide.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hist_l[i_q_entry.wr_addr] <= i_q_entry.sample_left;
            r_hist_r[i_q_entry.wr_addr] <= i_q_entry.sample_right;
            r_rd_l <= r_hist_l[i_q_entry.rd_addr];
            r_rd_r <= r_hist_r[i_q_entry.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_entry;
        end
        if (r_state == sdlm_pkg::BK_MUL) begin
            r_pd_l <= $signed({1'b0, r_cur.dry_gain}) * $signed(r_cur.sample_left);
            r_pd_r <= $signed({1'b0, r_cur.dry_gain}) * $signed(r_cur.sample_right);
            r_pw_l <= $signed({1'b0, r_cur.wet_k}) * delayed_l;
            r_pw_r <= $signed({1'b0, r_cur.wet_k}) * delayed_r;
        end
        if (load_out) begin
            r_out_l <= mix_sat(r_pd_l, r_pw_l);
            r_out_r <= mix_sat(r_pd_r, r_pw_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    `SDLM_ASSERT_IMPL(a_pop_only_idle, o_pop, (r_state == sdlm_pkg::BK_IDLE) && i_q_valid, "pop outside idle or from an empty queue")
    `SDLM_ASSERT_NEXT(a_mul_after_pop, o_pop, r_state == sdlm_pkg::BK_MUL, "popped item did not reach the multiply step")
    `SDLM_ASSERT_IMPL(a_load_from_sum, load_out, r_state == sdlm_pkg::BK_SUM, "result loaded outside the sum step")
    `SDLM_ASSERT_NEXT(a_sum_free_out, (r_state == sdlm_pkg::BK_SUM) && !r_out_valid, (r_state == sdlm_pkg::BK_IDLE) && r_out_valid, "sum step stalled with a free output register")

endmodule

[src/stereo_delay_line_mix.sv]
// Stereo delay line with wet/dry mix: top level joining front, queue and back.
// Each accepted item is one left/right sample pair; it yields exactly one mixed pair,
// dry_gain*x + 0.2*wet_gain*delayed per channel, rounded and saturated to 24 bits.
// The back part takes each item through its steps in order (memory write and read,
// multiply, sum and saturate) and pops a new item only after the last one has been
// loaded into the output register, which can stall while the output waits. A two-entry
// queue lets the input side take items while the back part works or the output waits.
// The two history memories hold 262144 samples each and need no clearing pass: a fill
// count marks entries not yet written since reset, and those read as zero. Configuration
// is to be written by the user only while the block is idle; the block does not enforce it.
module stereo_delay_line_mix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sdlm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sdlm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [23:0] sample_left, [47:24] sample_right
    input  logic [2*sdlm_pkg::SAMPLE_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [23:0] mixed_left, [47:24] mixed_right
    output logic [2*sdlm_pkg::SAMPLE_W-1:0]   m_axis_tdata
);

    logic                          push;
    logic                          full;
    logic                          pop;
    logic                          q_valid;
    sdlm_pkg::t_entry              push_entry;
    sdlm_pkg::t_entry              q_entry;
    logic [sdlm_pkg::SAMPLE_W-1:0] out_left;
    logic [sdlm_pkg::SAMPLE_W-1:0] out_right;

    sdlm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_s_left    (s_axis_tdata[sdlm_pkg::SAMPLE_W-1:0]),
        .i_s_right   (s_axis_tdata[2*sdlm_pkg::SAMPLE_W-1:sdlm_pkg::SAMPLE_W]),
        .o_push      (push),
        .o_entry     (push_entry),
        .i_full      (full)
    );

    sdlm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    sdlm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_left  (out_left),
        .o_m_right (out_right)
    );

    assign m_axis_tdata = {out_right, out_left};

endmodule
